// ===== hw/rtl/asc_pkg.sv =====
package asc_pkg;

  // Decoded command codes. Codes above the no-operation code do nothing.
  typedef enum logic [4:0] {
    CMD_HALT = 5'd0,
    CMD_LACC = 5'd1,
    CMD_LACM = 5'd2,
    CMD_LMAC = 5'd3,
    CMD_JMP  = 5'd4,
    CMD_JZ   = 5'd5,
    CMD_PUSH = 5'd6,
    CMD_POP  = 5'd7,
    CMD_ADD  = 5'd8,
    CMD_SUB  = 5'd9,
    CMD_INV  = 5'd10,
    CMD_INC  = 5'd11,
    CMD_WRIT = 5'd12,
    CMD_READ = 5'd13,
    CMD_LADR = 5'd14,
    CMD_LAC  = 5'd15,
    CMD_NOP  = 5'd16
  } cmd_e;

  // Pointer advance for the two instruction formats.
  localparam logic [15:0] ShortStep = 16'd1;
  localparam logic [15:0] LongStep  = 16'd3;
  // Stack pointer moves by one 16-bit word per push or pop.
  localparam logic [15:0] WordStep  = 16'd2;
  // Value loaded by the read command at end of input.
  localparam logic [15:0] EofValue  = 16'hffff;

  // One decoded instruction.
  typedef struct packed {
    cmd_e        command;
    logic [15:0] operand;
    logic        long_format;
    logic [7:0]  read_char;
    logic        read_eof;
  } item_t;

  // Architectural registers of the machine.
  typedef struct packed {
    logic [15:0] acc;
    logic [15:0] ip;
    logic [15:0] sp;
    logic [15:0] ar;
    logic        halted;
  } state_t;

  // Memory write requests and character output from the execute logic.
  typedef struct packed {
    logic        dm_we;
    logic        stk_we;
    logic        write_valid;
    logic [7:0]  write_char;
  } side_t;

endpackage

// ===== hw/rtl/asc_ram.sv =====
module asc_ram #(
  parameter int AW = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  localparam int Depth = 1 << AW;

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_q;
  logic [7:0] fwd_data_q;
  logic       fwd_q;

  // Byte array with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem_q[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  // A read in the same cycle as a write to the same byte returns the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (re_i) begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== hw/rtl/asc_exec.sv =====
module asc_exec (
  input  asc_pkg::item_t  item_i,
  input  asc_pkg::state_t state_i,
  input  logic [7:0]      dm_rdata_i,
  input  logic [15:0]     stk_word_i,
  output asc_pkg::state_t state_o,
  output asc_pkg::side_t  side_o
);

  import asc_pkg::*;

  logic jumped;

  // Execute one decoded instruction against the current machine state.
  always_comb begin
    state_o = state_i;
    side_o  = '0;
    jumped  = 1'b0;
    if (!state_i.halted) begin
      if (item_i.command == CMD_HALT) begin
        state_o.halted = 1'b1;
      end else if (item_i.long_format) begin
        unique case (item_i.command)
          CMD_LACC: state_o.acc = item_i.operand;
          CMD_LACM: state_o.acc = {8'h00, dm_rdata_i};
          CMD_LMAC: side_o.dm_we = 1'b1;
          CMD_JMP: begin
            state_o.ip = item_i.operand;
            jumped     = 1'b1;
          end
          CMD_JZ: begin
            if (state_i.acc == 16'h0000) begin
              state_o.ip = item_i.operand;
              jumped     = 1'b1;
            end
          end
          default: ;
        endcase
      end else begin
        unique case (item_i.command)
          CMD_PUSH: begin
            side_o.stk_we = 1'b1;
            state_o.sp    = state_i.sp + WordStep;
          end
          CMD_POP: begin
            state_o.sp  = state_i.sp - WordStep;
            state_o.acc = stk_word_i;
          end
          CMD_ADD:  state_o.acc = state_i.acc + stk_word_i;
          CMD_SUB:  state_o.acc = state_i.acc - stk_word_i;
          CMD_INV:  state_o.acc = ~state_i.acc;
          CMD_INC:  state_o.acc = state_i.acc + 16'd1;
          CMD_WRIT: begin
            side_o.write_valid = 1'b1;
            side_o.write_char  = state_i.acc[7:0];
          end
          CMD_READ: state_o.acc = item_i.read_eof ? EofValue : {8'h00, item_i.read_char};
          CMD_LADR: state_o.ar  = state_i.acc;
          CMD_LAC:  state_o.acc = {8'h00, dm_rdata_i};
          default: ;
        endcase
      end
      // Advance the pointer unless the machine halted or a jump was taken.
      if (!state_o.halted && !jumped) begin
        state_o.ip = state_i.ip + (item_i.long_format ? LongStep : ShortStep);
      end
    end
  end

endmodule

// ===== hw/rtl/accumulator_stack_cpu_step_top.sv =====
// Executes one decoded instruction of a 16-bit accumulator machine per item and returns the
// new pointer, accumulator, written character and halt flag. An item is taken in every
// cycle when the result side keeps up; it passes through the input register and then the
// result register. The execute stage updates the machine registers, and the next item's
// memory reads are issued from those updated values at the same edge, which sets the rate
// of one item per cycle. After reset the data memory and both stack banks are cleared one
// byte each per cycle, and no item is taken until the clearing pass is done. Both memories
// hold 2^ADDR_BITS bytes; addresses wrap at that size.
module accumulator_stack_cpu_step_top #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  command_i,
  input  logic [15:0] operand_i,
  input  logic        long_format_i,
  input  logic [7:0]  read_char_i,
  input  logic        read_eof_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] next_pointer_o,
  output logic [15:0] accumulator_value_o,
  output logic [7:0]  write_char_o,
  output logic        write_valid_o,
  output logic        halted_o
);

  import asc_pkg::*;

  localparam int BankBits = ADDR_BITS - 1;

  logic [ADDR_BITS:0]   clr_cnt_q;
  logic                 clr_done;
  logic                 in_accept;
  logic                 ex_valid_q;
  logic                 ex_fire;
  item_t                ex_item_q;
  logic                 ex_swap_q;
  state_t               st_q;
  state_t               st_d;
  state_t               nx;
  side_t                side;
  logic [7:0]           dm_rdata;
  logic [7:0]           even_rdata;
  logic [7:0]           odd_rdata;
  logic [15:0]          stk_word;
  logic                 dm_we;
  logic [ADDR_BITS-1:0] dm_waddr;
  logic [7:0]           dm_wdata;
  logic [ADDR_BITS-1:0] dm_raddr;
  logic [ADDR_BITS-1:0] push_addr;
  logic [ADDR_BITS-1:0] pop_addr;
  logic [BankBits-1:0]  push_even_idx;
  logic [BankBits-1:0]  pop_even_idx;
  logic                 stk_we;
  logic [BankBits-1:0]  even_waddr;
  logic [BankBits-1:0]  odd_waddr;
  logic [7:0]           even_wdata;
  logic [7:0]           odd_wdata;
  logic                 out_valid_q;
  logic [15:0]          out_ptr_q;
  logic [15:0]          out_acc_q;
  logic [7:0]           out_wchar_q;
  logic                 out_wvalid_q;
  logic                 out_halted_q;

  // Clearing pass over both memories after reset.
  assign clr_done = clr_cnt_q[ADDR_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (!clr_done) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Handshake: the execute stage fires when the result register is free or being emptied.
  assign ex_fire    = ex_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = clr_done && (!ex_valid_q || ex_fire);
  assign in_accept  = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else if (in_accept) begin
      ex_valid_q <= 1'b1;
    end else if (ex_fire) begin
      ex_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ex_item_q.command     <= cmd_e'(command_i);
      ex_item_q.operand     <= operand_i;
      ex_item_q.long_format <= long_format_i;
      ex_item_q.read_char   <= read_char_i;
      ex_item_q.read_eof    <= read_eof_i;
      ex_swap_q             <= pop_addr[0];
    end
  end

  // Execute stage.
  asc_exec u_exec (
    .item_i     (ex_item_q),
    .state_i    (st_q),
    .dm_rdata_i (dm_rdata),
    .stk_word_i (stk_word),
    .state_o    (nx),
    .side_o     (side)
  );

  assign st_d = ex_fire ? nx : st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  // Data memory: LAC reads use the address register after this step, others the operand.
  assign dm_raddr = (command_i == CMD_LAC) ? st_d.ar[ADDR_BITS-1:0]
                                           : operand_i[ADDR_BITS-1:0];
  assign dm_we    = !clr_done || (ex_fire && side.dm_we);
  assign dm_waddr = clr_done ? ex_item_q.operand[ADDR_BITS-1:0] : clr_cnt_q[ADDR_BITS-1:0];
  assign dm_wdata = clr_done ? st_q.acc[7:0] : 8'h00;

  asc_ram #(.AW(ADDR_BITS)) u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .re_i    (in_accept),
    .raddr_i (dm_raddr),
    .rdata_o (dm_rdata)
  );

  // Stack in two byte banks: a word at any byte address touches one entry in each bank.
  // An odd start address puts the low byte in the odd bank and the high byte in the
  // next even entry.
  assign push_addr     = st_q.sp[ADDR_BITS-1:0];
  assign pop_addr      = st_d.sp[ADDR_BITS-1:0] - WordStep[ADDR_BITS-1:0];
  assign push_even_idx = push_addr[ADDR_BITS-1:1] + {{(BankBits-1){1'b0}}, push_addr[0]};
  assign pop_even_idx  = pop_addr[ADDR_BITS-1:1] + {{(BankBits-1){1'b0}}, pop_addr[0]};

  assign stk_we     = !clr_done || (ex_fire && side.stk_we);
  assign even_waddr = clr_done ? push_even_idx : clr_cnt_q[BankBits-1:0];
  assign odd_waddr  = clr_done ? push_addr[ADDR_BITS-1:1] : clr_cnt_q[BankBits-1:0];
  assign even_wdata = !clr_done ? 8'h00 : (push_addr[0] ? st_q.acc[15:8] : st_q.acc[7:0]);
  assign odd_wdata  = !clr_done ? 8'h00 : (push_addr[0] ? st_q.acc[7:0] : st_q.acc[15:8]);

  asc_ram #(.AW(BankBits)) u_stk_even (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (stk_we),
    .waddr_i (even_waddr),
    .wdata_i (even_wdata),
    .re_i    (in_accept),
    .raddr_i (pop_even_idx),
    .rdata_o (even_rdata)
  );

  asc_ram #(.AW(BankBits)) u_stk_odd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (stk_we),
    .waddr_i (odd_waddr),
    .wdata_i (odd_wdata),
    .re_i    (in_accept),
    .raddr_i (pop_addr[ADDR_BITS-1:1]),
    .rdata_o (odd_rdata)
  );

  assign stk_word = ex_swap_q ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ex_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      out_ptr_q    <= nx.ip;
      out_acc_q    <= nx.acc;
      out_wchar_q  <= side.write_char;
      out_wvalid_q <= side.write_valid;
      out_halted_q <= nx.halted;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign next_pointer_o      = out_ptr_q;
  assign accumulator_value_o = out_acc_q;
  assign write_char_o        = out_wchar_q;
  assign write_valid_o       = out_wvalid_q;
  assign halted_o            = out_halted_q;

`ifndef SYNTHESIS
  // No item is taken before the memories are cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> clr_done)
    else $error("item taken during clearing pass");

  // A stalled execute stage blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_valid_q && !ex_fire) |-> !in_ready_o)
    else $error("input open while execute stage stalled");

  // Once halted, the machine registers never change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clr_done && st_q.halted) |=> (st_q.halted && $stable(st_q)))
    else $error("state changed after halt");

  // The stack pointer only moves by one word per step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_done |=> ((st_q.sp == $past(st_q.sp)) || (st_q.sp == $past(st_q.sp) + WordStep)
                  || (st_q.sp == $past(st_q.sp) - WordStep)))
    else $error("stack pointer jumped");

  // After clearing, memories are written only by an executing item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clr_done && !ex_fire) |-> (!dm_we && !stk_we))
    else $error("memory written without an executing item");
`endif

endmodule
